@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the divider and the walk module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, prop, msg)
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif

`endif

@@ hdl/itna_pkg.sv @@
package itna_pkg;

  // Field and register widths.
  localparam int ADDR_W     = 48;
  localparam int NB_W       = 13;
  localparam int PF_W       = 7;
  localparam int LV_W       = 5;
  localparam int INNER_W    = 40;
  localparam int SLOT_W     = 6;
  localparam int LEVEL_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_DATA_W = 64;

  // Node ids stay below 2^48: inner count below 2^40 plus a quotient below 2^47.
  localparam int ID_W   = 48;
  localparam int PROD_W = ID_W + NB_W;
  localparam int SUM_W  = PROD_W + 1;

  // Divider and multiplier step counts.
  localparam int DIV_STEPS = ID_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int MUL_STEPS = NB_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  // Limits applied to the configuration values.
  localparam logic [PF_W-1:0] PF_MIN     = PF_W'(2);
  localparam logic [PF_W-1:0] PF_MAX     = PF_W'(64);
  localparam logic [LV_W-1:0] MAX_LEVELS = LV_W'(16);

  // Reset values of the configuration registers.
  localparam logic [NB_W-1:0]    RST_BUS_BYTES  = NB_W'(64);
  localparam logic [PF_W-1:0]    RST_PACKING    = PF_W'(8);
  localparam logic [LV_W-1:0]    RST_LEVELS     = LV_W'(4);
  localparam logic [NB_W-1:0]    RST_NODE_BYTES = NB_W'(64);
  localparam logic [INNER_W-1:0] RST_INNER      = INNER_W'(585);
  localparam logic [ADDR_W-1:0]  RST_BASE       = '0;
  localparam logic [ADDR_W-1:0]  RST_END        = '0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUS_BYTES      = 3'd0,
    REG_PACKING_FACTOR = 3'd1,
    REG_TREE_LEVELS    = 3'd2,
    REG_NODE_BYTES     = 3'd3,
    REG_INNER_COUNT    = 3'd4,
    REG_REGION_BASE    = 3'd5,
    REG_REGION_END     = 3'd6
  } reg_idx_t;

  // Effective configuration, with out-of-range values already clamped.
  typedef struct packed {
    logic [NB_W-1:0]    ctr_bytes;
    logic [PF_W-1:0]    fanout;
    logic [LV_W-1:0]    tree_levels;
    logic [NB_W-1:0]    node_bytes;
    logic [INNER_W-1:0] inner_node_count;
    logic [ADDR_W-1:0]  region_base;
    logic [ADDR_W-1:0]  region_end;
  } cfg_t;

endpackage

@@ hdl/itna_cfg.sv @@
module itna_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [itna_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [itna_pkg::ADDR_W-1:0]      cfg_data,
  output itna_pkg::cfg_t                   cfg
);

  logic [itna_pkg::NB_W-1:0]    ctr_bytes;
  logic [itna_pkg::PF_W-1:0]    fanout;
  logic [itna_pkg::LV_W-1:0]    tree_levels;
  logic [itna_pkg::NB_W-1:0]    node_bytes;
  logic [itna_pkg::INNER_W-1:0] inner_node_count;
  logic [itna_pkg::ADDR_W-1:0]  region_base;
  logic [itna_pkg::ADDR_W-1:0]  region_end;

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_bytes        <= itna_pkg::RST_BUS_BYTES;
      fanout           <= itna_pkg::RST_PACKING;
      tree_levels      <= itna_pkg::RST_LEVELS;
      node_bytes       <= itna_pkg::RST_NODE_BYTES;
      inner_node_count <= itna_pkg::RST_INNER;
      region_base      <= itna_pkg::RST_BASE;
      region_end       <= itna_pkg::RST_END;
    end else if (cfg_valid) begin
      case (cfg_index)
        itna_pkg::REG_BUS_BYTES:      ctr_bytes        <= cfg_data[itna_pkg::NB_W-1:0];
        itna_pkg::REG_PACKING_FACTOR: fanout           <= cfg_data[itna_pkg::PF_W-1:0];
        itna_pkg::REG_TREE_LEVELS:    tree_levels      <= cfg_data[itna_pkg::LV_W-1:0];
        itna_pkg::REG_NODE_BYTES:     node_bytes       <= cfg_data[itna_pkg::NB_W-1:0];
        itna_pkg::REG_INNER_COUNT:    inner_node_count <= cfg_data[itna_pkg::INNER_W-1:0];
        itna_pkg::REG_REGION_BASE:    region_base      <= cfg_data;
        itna_pkg::REG_REGION_END:     region_end       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the values the datapath must never see out of range.
  always_comb begin
    cfg.ctr_bytes = (ctr_bytes == '0) ? itna_pkg::NB_W'(1) : ctr_bytes;
    if (fanout < itna_pkg::PF_MIN) begin
      cfg.fanout = itna_pkg::PF_MIN;
    end else if (fanout > itna_pkg::PF_MAX) begin
      cfg.fanout = itna_pkg::PF_MAX;
    end else begin
      cfg.fanout = fanout;
    end
    if (tree_levels == '0) begin
      cfg.tree_levels = itna_pkg::LV_W'(1);
    end else if (tree_levels > itna_pkg::MAX_LEVELS) begin
      cfg.tree_levels = itna_pkg::MAX_LEVELS;
    end else begin
      cfg.tree_levels = tree_levels;
    end
    cfg.node_bytes       = node_bytes;
    cfg.inner_node_count = inner_node_count;
    cfg.region_base      = region_base;
    cfg.region_end       = region_end;
  end

endmodule

@@ hdl/itna_div.sv @@
`include "assert_macros.svh"

module itna_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [itna_pkg::ID_W-1:0]   dividend,
  input  logic [itna_pkg::NB_W-1:0]   divisor,
  output logic                        done,
  output logic [itna_pkg::ID_W-1:0]   quotient,
  output logic [itna_pkg::NB_W-1:0]   remainder
);

  localparam logic [itna_pkg::DIV_CNT_W-1:0] LAST_STEP =
    itna_pkg::DIV_CNT_W'(itna_pkg::DIV_STEPS - 1);

  logic                              busy;
  logic [itna_pkg::DIV_CNT_W-1:0]    cnt;
  logic [itna_pkg::ID_W-1:0]         quo;
  logic [itna_pkg::NB_W-1:0]         rem;
  logic [itna_pkg::NB_W-1:0]         dvs;
  logic [itna_pkg::NB_W:0]           trial;
  logic                              qbit;
  logic [itna_pkg::NB_W-1:0]         rem_next;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem, quo[itna_pkg::ID_W-1]};
    qbit  = (trial >= {1'b0, dvs});
    if (qbit) begin
      rem_next = itna_pkg::NB_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[itna_pkg::NB_W-1:0];
    end
  end

  // Step sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= LAST_STEP;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[itna_pkg::ID_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  `ASSERT_IMPLIES(a_div_rem_below_divisor, clk, rst, done, rem < dvs, "remainder not reduced")
  `ASSERT_IMPLIES(a_div_done_idle, clk, rst, done, !busy, "divider done while busy")
  `ASSERT_NEXT(a_div_start_busy, clk, rst, start, busy, "divider did not start")

endmodule

@@ hdl/itna_mul.sv @@
module itna_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [itna_pkg::ID_W-1:0]     multiplicand,
  input  logic [itna_pkg::NB_W-1:0]     multiplier,
  output logic                          done,
  output logic [itna_pkg::PROD_W-1:0]   product
);

  localparam logic [itna_pkg::MUL_CNT_W-1:0] LAST_STEP =
    itna_pkg::MUL_CNT_W'(itna_pkg::MUL_STEPS - 1);

  logic                              busy;
  logic [itna_pkg::MUL_CNT_W-1:0]    cnt;
  logic [itna_pkg::PROD_W-1:0]       acc;
  logic [itna_pkg::PROD_W-1:0]       mcand;
  logic [itna_pkg::NB_W-1:0]         mplier;

  // Step sequencing, one multiplier bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= LAST_STEP;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift-and-add accumulation.
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= itna_pkg::PROD_W'(multiplicand);
      mplier <= multiplier;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[itna_pkg::PROD_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[itna_pkg::NB_W-1:1]};
    end
  end

  assign product = acc;

endmodule

@@ hdl/integrity_tree_node_address_walk.sv @@
// Walks one data address from the leaf level to the root, one result per level.
// Steps: a range check, a 48-step divide by the counter bytes, a 48-step divide by
// the arity into leaf node and slot, a 13-step multiply by the node size; each further
// level repeats one divide by the arity and one multiply. A data address inside the
// region is answered by an error result from the range check. One item at a time,
// through one shared divider. Reset (rst, synchronous, active high) idles the walk
// and restores the register defaults.
`include "assert_macros.svh"

module integrity_tree_node_address_walk (
  input  logic                                clk,
  input  logic                                rst,
  // Input transactions.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [itna_pkg::ADDR_W-1:0]         s_axis_tdata,  // [47:0] data address
  // Result transactions.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [47:0] node address, [53:48] child_slot, [57:54] level, [63:58] zero
  output logic [itna_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tuser,  // [0] error
  output logic                                m_axis_tlast,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [itna_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [itna_pkg::ADDR_W-1:0]         cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_CTR,
    ST_DIV_LEAF,
    ST_MUL,
    ST_SUM,
    ST_PUT,
    ST_DIV_UP
  } state_t;

  itna_pkg::cfg_t                        cfg;
  state_t                                state;
  logic [itna_pkg::ADDR_W-1:0]           addr_q;
  logic [itna_pkg::ID_W-1:0]             id;
  logic [itna_pkg::SLOT_W-1:0]           slot;
  logic [itna_pkg::LEVEL_W-1:0]          level;
  logic [itna_pkg::SUM_W-1:0]            na_sum;
  logic                                  div_start;
  logic [itna_pkg::ID_W-1:0]             div_a;
  logic [itna_pkg::NB_W-1:0]             div_b;
  logic                                  div_done;
  logic [itna_pkg::ID_W-1:0]             div_quo;
  logic [itna_pkg::NB_W-1:0]             div_rem;
  logic                                  mul_start;
  logic                                  mul_done;
  logic [itna_pkg::PROD_W-1:0]           mul_prod;
  logic [itna_pkg::ADDR_W-1:0]           res_addr;
  logic [itna_pkg::SLOT_W-1:0]           res_slot;
  logic                                  res_err;
  logic                                  res_last;
  logic [itna_pkg::ADDR_W-1:0]           out_addr;
  logic [itna_pkg::SLOT_W-1:0]           out_slot;
  logic [itna_pkg::LEVEL_W-1:0]          out_level;
  logic                                  addr_in_region;
  logic                                  na_ok;
  logic                                  top_level;
  logic                                  out_free;
  logic [itna_pkg::ID_W-1:0]             leaf_id;

  itna_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  itna_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  itna_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (id),
    .multiplier   (cfg.node_bytes),
    .done         (mul_done),
    .product      (mul_prod)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {{(itna_pkg::OUT_DATA_W - itna_pkg::ADDR_W - itna_pkg::SLOT_W
                           - itna_pkg::LEVEL_W){1'b0}}, out_level, out_slot, out_addr};

  // Range checks on the input address and on the node address of this level.
  always_comb begin
    addr_in_region = (addr_q >= cfg.region_base) && (addr_q < cfg.region_end);
    na_ok = (na_sum[itna_pkg::SUM_W-1:itna_pkg::ADDR_W] == '0)
         && (na_sum[itna_pkg::ADDR_W-1:0] >= cfg.region_base)
         && (na_sum[itna_pkg::ADDR_W-1:0] < cfg.region_end);
    top_level = ({1'b0, level} + itna_pkg::LV_W'(1)) == cfg.tree_levels;
    out_free  = !m_axis_tvalid || m_axis_tready;
    leaf_id   = itna_pkg::ID_W'(cfg.inner_node_count) + div_quo;
  end

  // Sequencer, unit operands and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      div_start     <= 1'b0;
      mul_start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      mul_start <= 1'b0;
      // An accepted result empties the output register unless a new one is loaded.
      if (m_axis_tvalid && m_axis_tready && (state != ST_PUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            addr_q <= s_axis_tdata;
            level  <= '0;
            state  <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (addr_in_region) begin
            res_addr <= '0;
            res_slot <= '0;
            res_err  <= 1'b1;
            res_last <= 1'b1;
            state    <= ST_PUT;
          end else begin
            div_start <= 1'b1;
            div_a     <= itna_pkg::ID_W'(addr_q);
            div_b     <= cfg.ctr_bytes;
            state     <= ST_DIV_CTR;
          end
        end
        ST_DIV_CTR: begin
          // Counter index is known; split it into leaf node and slot.
          if (div_done) begin
            div_start <= 1'b1;
            div_a     <= div_quo;
            div_b     <= itna_pkg::NB_W'(cfg.fanout);
            state     <= ST_DIV_LEAF;
          end
        end
        ST_DIV_LEAF: begin
          if (div_done) begin
            id        <= leaf_id;
            slot      <= div_rem[itna_pkg::SLOT_W-1:0];
            mul_start <= 1'b1;
            state     <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            na_sum <= itna_pkg::SUM_W'(cfg.region_base) + itna_pkg::SUM_W'(mul_prod);
            state  <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (na_ok) begin
            res_addr <= na_sum[itna_pkg::ADDR_W-1:0];
            res_slot <= slot;
            res_err  <= 1'b0;
            res_last <= top_level;
          end else begin
            res_addr <= '0;
            res_slot <= '0;
            res_err  <= 1'b1;
            res_last <= 1'b1;
          end
          state <= ST_PUT;
        end
        ST_PUT: begin
          // Hand the result over, then climb one level unless the run is over.
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_addr      <= res_addr;
            out_slot      <= res_slot;
            out_level     <= level;
            m_axis_tuser  <= res_err;
            m_axis_tlast  <= res_last;
            if (res_last) begin
              state <= ST_IDLE;
            end else begin
              level     <= level + 1'b1;
              div_start <= 1'b1;
              div_a     <= id;
              div_b     <= itna_pkg::NB_W'(cfg.fanout);
              state     <= ST_DIV_UP;
            end
          end
        end
        ST_DIV_UP: begin
          if (div_done) begin
            id        <= div_quo;
            slot      <= div_rem[itna_pkg::SLOT_W-1:0];
            mul_start <= 1'b1;
            state     <= ST_MUL;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_err_ends_run, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tlast,
    "error result without last")
  `ASSERT_IMPLIES(a_level_in_range, clk, rst, m_axis_tvalid,
    {1'b0, out_level} < cfg.tree_levels, "level past configured depth")
  `ASSERT_IMPLIES(a_node_in_region, clk, rst, m_axis_tvalid && !m_axis_tuser,
    (out_addr >= cfg.region_base) && (out_addr < cfg.region_end), "node address outside region")

endmodule

@@ dv/node_walk_checker.sv @@
`timescale 1ns / 1ps

// Watches the input, result and configuration channels of the node address walk,
// predicts the node path of every accepted data address and compares each result
// transaction against the oldest outstanding prediction.
module node_walk_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [itna_pkg::ADDR_W-1:0]     s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [itna_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tuser,
  input  logic                            m_axis_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [itna_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [itna_pkg::ADDR_W-1:0]     cfg_data,
  output int                              mismatches,
  output int                              pending_results
);

  // Beyond this many failures the count goes on but the log stays quiet.
  localparam int REPORT_CAP = 40;
  localparam int PAD_LO     = itna_pkg::ADDR_W + itna_pkg::SLOT_W + itna_pkg::LEVEL_W;

  // One predicted result: the node visited at one tree level.
  typedef struct packed {
    logic [itna_pkg::ADDR_W-1:0]  node_addr;
    logic [itna_pkg::SLOT_W-1:0]  child_slot;
    logic [itna_pkg::LEVEL_W-1:0] level;
    logic                         error;
    logic                         last;
  } node_hop_t;

  // Register values as written, before any clamping.
  logic [itna_pkg::NB_W-1:0]    ctr_bytes;
  logic [itna_pkg::PF_W-1:0]    fanout;
  logic [itna_pkg::LV_W-1:0]    tree_levels;
  logic [itna_pkg::NB_W-1:0]    node_bytes;
  logic [itna_pkg::INNER_W-1:0] inner_node_count;
  logic [itna_pkg::ADDR_W-1:0]  region_base;
  logic [itna_pkg::ADDR_W-1:0]  region_end;

  node_hop_t expected_hops[$];
  int        cycle_faults;

  function automatic bit in_meta_region(input logic [63:0] addr);
    return addr >= 64'(region_base) && addr < 64'(region_end);
  endfunction

  // Predict the whole path of one data address, leaf level first.
  function automatic void walk_tree_path(input logic [itna_pkg::ADDR_W-1:0] prot_addr);
    logic [63:0] stride;
    logic [63:0] arity;
    logic [63:0] levels;
    logic [63:0] counter;
    logic [63:0] node_id;
    logic [63:0] slot;
    logic [63:0] sum_addr;
    node_hop_t   hop;
    stride = (ctr_bytes == 0) ? 64'd1 : 64'(ctr_bytes);
    arity  = (fanout < itna_pkg::PF_MIN) ? 64'(itna_pkg::PF_MIN) :
             (fanout > itna_pkg::PF_MAX) ? 64'(itna_pkg::PF_MAX) : 64'(fanout);
    levels = (tree_levels == 0) ? 64'd1 :
             (tree_levels > itna_pkg::MAX_LEVELS) ? 64'(itna_pkg::MAX_LEVELS) :
             64'(tree_levels);
    hop       = '0;
    hop.error = 1'b1;
    hop.last  = 1'b1;

    // A data address inside the metadata region is refused at once.
    if (in_meta_region(64'(prot_addr))) begin
      expected_hops.push_back(hop);
      return;
    end

    counter = 64'(prot_addr) / stride;
    node_id = 64'(inner_node_count) + counter / arity;
    slot    = counter % arity;

    // The id stays below 2^48 and node_bytes below 2^13, so the sum fits in 64 bits.
    // A sum past 48 bits fails the region test because region_end is below 2^48.
    for (int lvl = 0; lvl < levels; lvl++) begin
      sum_addr  = 64'(region_base) + node_id * 64'(node_bytes);
      hop.level = itna_pkg::LEVEL_W'(lvl);
      if (!in_meta_region(sum_addr)) begin
        hop.node_addr  = '0;
        hop.child_slot = '0;
        hop.error      = 1'b1;
        hop.last       = 1'b1;
        expected_hops.push_back(hop);
        return;
      end
      hop.node_addr  = sum_addr[itna_pkg::ADDR_W-1:0];
      hop.child_slot = slot[itna_pkg::SLOT_W-1:0];
      hop.error      = 1'b0;
      hop.last       = (lvl + 1 == levels);
      expected_hops.push_back(hop);
      slot    = node_id % arity;
      node_id = node_id / arity;
    end
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      cycle_faults++;
      if (mismatches + cycle_faults <= REPORT_CAP)
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endtask

  // Track configuration, predict on input transactions, compare result transactions.
  always @(posedge clk) begin : watch_channels
    node_hop_t hop;
    cycle_faults = 0;
    if (rst) begin
      ctr_bytes        = itna_pkg::RST_BUS_BYTES;
      fanout           = itna_pkg::RST_PACKING;
      tree_levels      = itna_pkg::RST_LEVELS;
      node_bytes       = itna_pkg::RST_NODE_BYTES;
      inner_node_count = itna_pkg::RST_INNER;
      region_base      = itna_pkg::RST_BASE;
      region_end       = itna_pkg::RST_END;
      expected_hops.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          itna_pkg::REG_BUS_BYTES:      ctr_bytes        = cfg_data[itna_pkg::NB_W-1:0];
          itna_pkg::REG_PACKING_FACTOR: fanout           = cfg_data[itna_pkg::PF_W-1:0];
          itna_pkg::REG_TREE_LEVELS:    tree_levels      = cfg_data[itna_pkg::LV_W-1:0];
          itna_pkg::REG_NODE_BYTES:     node_bytes       = cfg_data[itna_pkg::NB_W-1:0];
          itna_pkg::REG_INNER_COUNT:    inner_node_count = cfg_data[itna_pkg::INNER_W-1:0];
          itna_pkg::REG_REGION_BASE:    region_base      = cfg_data;
          itna_pkg::REG_REGION_END:     region_end       = cfg_data;
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready)
        walk_tree_path(s_axis_tdata);

      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_hops.size() == 0) begin
          cycle_faults++;
          if (mismatches + cycle_faults <= REPORT_CAP)
            $error("result with nothing expected: tdata 0x%0h, tuser %b, tlast %b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          hop = expected_hops[0];
          expected_hops.delete(0);
          check_field("node_addr", 64'(hop.node_addr),
                      64'(m_axis_tdata[itna_pkg::ADDR_W-1:0]));
          check_field("child_slot", 64'(hop.child_slot),
                      64'(m_axis_tdata[itna_pkg::ADDR_W +: itna_pkg::SLOT_W]));
          check_field("level", 64'(hop.level),
                      64'(m_axis_tdata[itna_pkg::ADDR_W+itna_pkg::SLOT_W +: itna_pkg::LEVEL_W]));
          check_field("padding", 64'd0, 64'(m_axis_tdata[itna_pkg::OUT_DATA_W-1:PAD_LO]));
          check_field("error", 64'(hop.error), 64'(m_axis_tuser));
          check_field("last", 64'(hop.last), 64'(m_axis_tlast));
        end
      end
    end
    pending_results <= expected_hops.size();
    mismatches      <= rst ? 0 : mismatches + cycle_faults;
  end

endmodule

@@ dv/integrity_tree_node_address_walk_test.sv @@
`timescale 1ns / 1ps

// Drives data addresses and register writes into the node address walk, with
// random gaps on the input side and random stalls on the result side.
module integrity_tree_node_address_walk_test;

  localparam int TOTAL_ITEMS    = 470;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 150;
  // Index 7 is not a register; writes to it must change nothing.
  localparam logic [itna_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic [63:0] ADDR_TOP = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] HALF_SPACE = 64'h8000_0000_0000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [itna_pkg::ADDR_W-1:0]     s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [itna_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [itna_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [itna_pkg::ADDR_W-1:0]     cfg_data = '0;
  int                              mismatches;
  int                              pending_results;

  int          idle_cycles = 0;
  int          ready_hold = 0;
  int          items_sent = 0;
  bit          steady_feed = 1'b0;
  // Shape of the current address mix: data window and metadata region.
  logic [63:0] addr_window = 64'd1 << 20;
  logic [63:0] meta_base = '0;
  logic [63:0] meta_end = '0;

  always #4 clk = ~clk;

  integrity_tree_node_address_walk i_dut (.*);

  node_walk_checker i_checker (.*);

  // Result side: bursts of readiness, short and long stalls, and free-running stretches.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else begin
      case ($urandom_range(0, 15))
        0, 1: begin
          m_axis_tready = 1'b1;
          ready_hold    = $urandom_range(100, 300);
        end
        2, 3, 4, 5, 6, 7, 8, 9: begin
          m_axis_tready = 1'b1;
          ready_hold    = $urandom_range(0, 7);
        end
        10, 11, 12, 13: begin
          m_axis_tready = 1'b0;
          ready_hold    = $urandom_range(0, 2);
        end
        default: begin
          m_axis_tready = 1'b0;
          ready_hold    = $urandom_range(20, 60);
        end
      endcase
    end
  end

  // Stop the run when no transaction of any kind completes for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    if (steady_feed) return 0;
    if ($urandom_range(0, 7) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 2);
  endfunction

  // Mostly addresses in the data window; some inside the region, on its edges, or anywhere.
  function automatic logic [itna_pkg::ADDR_W-1:0] pick_data_address();
    logic [63:0] addr;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    addr = {$urandom, $urandom};
    if (pick < 15) begin
      addr = addr & (addr_window - 1);
    end else if (pick < 17 && meta_end > meta_base) begin
      addr = meta_base + addr % (meta_end - meta_base);
    end else if (pick == 17) begin
      case ($urandom_range(0, 3))
        0:       addr = meta_base - 1;
        1:       addr = meta_base;
        2:       addr = meta_end - 1;
        default: addr = meta_end;
      endcase
    end
    return addr[itna_pkg::ADDR_W-1:0];
  endfunction

  // Bytes of metadata needed so that every node id reached from the window fits.
  function automatic logic [63:0] region_span(input logic [63:0] window,
      input logic [63:0] bus, input logic [63:0] arity, input logic [63:0] node,
      input logic [63:0] inner);
    logic [63:0] bus_eff;
    logic [63:0] arity_eff;
    bus_eff   = (bus == 0) ? 64'd1 : bus;
    arity_eff = (arity < 2) ? 64'd2 : (arity > 64) ? 64'd64 : arity;
    return (inner + ((window - 1) / bus_eff) / arity_eff + 1) * ((node == 0) ? 64'd1 : node);
  endfunction

  task automatic write_reg(input logic [itna_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value[itna_pkg::ADDR_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_config(input logic [63:0] bus, input logic [63:0] arity,
      input logic [63:0] levels, input logic [63:0] node, input logic [63:0] inner,
      input logic [63:0] lo, input logic [63:0] hi);
    write_reg(itna_pkg::REG_BUS_BYTES, bus);
    write_reg(itna_pkg::REG_PACKING_FACTOR, arity);
    write_reg(itna_pkg::REG_TREE_LEVELS, levels);
    write_reg(itna_pkg::REG_NODE_BYTES, node);
    write_reg(itna_pkg::REG_INNER_COUNT, inner);
    write_reg(itna_pkg::REG_REGION_BASE, lo);
    write_reg(itna_pkg::REG_REGION_END, hi);
    meta_base = lo & ADDR_TOP;
    meta_end  = hi & ADDR_TOP;
  endtask

  task automatic send_address(input logic [63:0] addr, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = addr[itna_pkg::ADDR_W-1:0];
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  // Let every outstanding result come back before touching the registers.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_results != 0) @(posedge clk);
  endtask

  // One random configuration followed by a batch of addresses under it.
  task automatic random_phase(input int count);
    logic [63:0] bus;
    logic [63:0] arity;
    logic [63:0] levels;
    logic [63:0] node;
    logic [63:0] inner;
    logic [63:0] span;
    logic [63:0] lo;
    logic [63:0] hi;
    int unsigned pick;

    pick = $urandom_range(0, 9);
    bus  = (pick == 0) ? 64'd0 : (pick == 1) ? 64'd1 : (pick == 2) ? 64'd4096 :
           64'($urandom_range(1, 4096));
    if ($urandom_range(0, 9) == 0)
      arity = $urandom_range(0, 1) ? 64'($urandom_range(0, 1)) : 64'($urandom_range(65, 127));
    else
      arity = 64'($urandom_range(2, 64));
    pick = $urandom_range(0, 19);
    if (pick == 0)
      levels = $urandom_range(0, 1) ? 64'd0 : 64'($urandom_range(17, 31));
    else if (pick < 3)
      levels = 64'($urandom_range(6, 16));
    else
      levels = 64'($urandom_range(1, 5));
    node = ($urandom_range(0, 11) == 0) ? 64'd0 : 64'($urandom_range(1, 4096));
    case ($urandom_range(0, 2))
      0:       inner = 64'($urandom_range(0, 1023));
      1:       inner = 64'($urandom_range(0, 1 << 24));
      default: inner = 64'($urandom);
    endcase

    // Shrink the data window until the region fits above it.
    addr_window = 64'd1 << $urandom_range(8, 44);
    span = region_span(addr_window, bus, arity, node, inner);
    while (addr_window > 256 && addr_window + span >= ADDR_TOP) begin
      addr_window = addr_window >> 1;
      span = region_span(addr_window, bus, arity, node, inner);
    end
    if (addr_window + span < ADDR_TOP) begin
      lo = addr_window + {$urandom, $urandom} % (ADDR_TOP - addr_window - span + 1);
      hi = lo + span + 64'($urandom_range(0, 4095));
      if (hi > ADDR_TOP) hi = ADDR_TOP;
    end else begin
      lo = {$urandom, $urandom} & ADDR_TOP;
      hi = {$urandom, $urandom} & ADDR_TOP;
    end

    load_config(bus, arity, levels, node, inner, lo, hi);
    steady_feed = ($urandom_range(0, 3) == 0);
    repeat (count) send_address(pick_data_address(), pick_gap());
    wait_idle();
  endtask

  initial begin
    int batch;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset values leave the region empty, so every walk fails at the leaf.
    send_address(64'd0, 0);
    send_address(ADDR_TOP, 1);
    wait_idle();

    // Region in the upper half; addresses on both sides of its edges.
    load_config(64'd64, 64'd8, 64'd4, 64'd64, 64'd585, HALF_SPACE, ADDR_TOP);
    send_address(64'd0, 0);
    send_address(HALF_SPACE - 1, 0);
    send_address(HALF_SPACE, 2);
    send_address(ADDR_TOP - 1, 0);
    send_address(ADDR_TOP, 0);
    send_address(64'h5555_5555_5555, 3);
    send_address(64'hAAAA_AAAA_AAAA, 0);
    wait_idle();

    // Zero bus and node sizes, arity and level count below their minimum.
    load_config(64'd0, 64'd1, 64'd0, 64'd0, 64'hFF_FFFF_FFFF, 64'h10, 64'h20);
    send_address(64'd0, 0);
    send_address(64'h18, 0);
    send_address(ADDR_TOP, 0);
    wait_idle();

    // All-ones writes get cut to each register's width; a write past the list is dropped.
    write_reg(REG_SPARE, ADDR_TOP);
    load_config(ADDR_TOP, ADDR_TOP, ADDR_TOP, 64'd1, 64'hFF00_0000_0000, 64'h1_0000_0000,
                ADDR_TOP);
    write_reg(REG_SPARE, 64'h0);
    send_address(64'd0, 0);
    send_address(64'hFFFF_FFFF, 1);
    wait_idle();

    // The node address sum runs past the address width.
    load_config(64'd4096, 64'd65, 64'd17, 64'd8191, 64'hFF_FFFF_FFFF, HALF_SPACE, ADDR_TOP);
    send_address(64'd0, 0);
    wait_idle();

    // Largest arity and level count, 4096-byte bus and node sizes, and a full sixteen-level walk.
    load_config(64'd4096, 64'd64, 64'd16, 64'd4096, 64'd0, 64'h100_0000_0000, ADDR_TOP);
    send_address(64'd0, 0);
    send_address(64'hFF_FFFF_FFFF, 0);
    wait_idle();

    // Region base above its end: the region is empty.
    write_reg(itna_pkg::REG_REGION_BASE, ADDR_TOP);
    write_reg(itna_pkg::REG_REGION_END, 64'd0);
    meta_base = ADDR_TOP;
    meta_end  = 64'd0;
    send_address(64'd0, 0);
    send_address(ADDR_TOP, 0);
    wait_idle();

    // Random batches, the last one cut so the item total lands on target.
    while (items_sent < TOTAL_ITEMS) begin
      batch = $urandom_range(30, 70);
      if (batch > TOTAL_ITEMS - items_sent) batch = TOTAL_ITEMS - items_sent;
      random_phase(batch);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
